@@ sv/plc_pkg.sv @@
// package: types and constants shared by the positional list modules
`default_nettype none
package plc_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_INS,
    CMD_DEL
  } cmd_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [IDX_W-1:0]  p0;
    logic [DATA_W-1:0] val;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ sv/plc_cell.sv @@
// one list slot: holds an entry and shifts with its neighbors on insert or delete
`default_nettype none
module plc_cell (
  input  wire logic                       clk_i,
  input  wire plc_pkg::cell_ctl_t         ctl_i,
  input  wire logic [plc_pkg::IDX_W-1:0]  idx_i,
  input  wire logic [plc_pkg::DATA_W-1:0] left_i,
  input  wire logic [plc_pkg::DATA_W-1:0] right_i,
  output logic      [plc_pkg::DATA_W-1:0] entry_o,
  output logic      [plc_pkg::DATA_W-1:0] hit_o
);

  logic [plc_pkg::DATA_W-1:0] entry_q, entry_d;
  logic                       at_pos, past_pos;

  assign at_pos   = (idx_i == ctl_i.p0);
  assign past_pos = (idx_i > ctl_i.p0);

  always_comb begin
    entry_d = entry_q;
    case (ctl_i.cmd)
      plc_pkg::CMD_INS: begin
        if (at_pos) begin
          entry_d = ctl_i.val;
        end else if (past_pos) begin
          entry_d = left_i;
        end
      end
      plc_pkg::CMD_DEL: begin
        if (at_pos || past_pos) begin
          entry_d = right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign hit_o   = at_pos ? entry_q : '0;

endmodule
`default_nettype wire

@@ sv/plc_ctrl.sv @@
// controller: command latch, bounds checks, count and result register
`default_nettype none
module plc_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [1:0]                 func_i,
  input  wire logic [plc_pkg::POS_W-1:0]  position_i,
  input  wire logic [plc_pkg::DATA_W-1:0] value_in_i,
  input  wire logic [plc_pkg::DATA_W-1:0] rd_value_i,
  output plc_pkg::cell_ctl_t              ctl_o,
  output logic                            busy_o,
  output logic                            done_o,
  output logic                            ok_o,
  output logic      [plc_pkg::DATA_W-1:0] value_out_o,
  output logic      [5:0]                 count_out_o
);

  plc_pkg::state_e             state_q, state_d;
  plc_pkg::func_e              func_q;
  logic [plc_pkg::POS_W-1:0]   pos_q;
  logic [plc_pkg::DATA_W-1:0]  val_q;
  logic [plc_pkg::CNT_W-1:0]   count_q, count_d;
  logic                        done_q, ok_q, ok_d;
  logic [plc_pkg::DATA_W-1:0]  vout_q, vout_d;
  logic [plc_pkg::CMP_W-1:0]   pos_ext, cnt_ext;
  logic                        in_range, ins_range, exec;
  plc_pkg::cmd_e               cmd;

  assign exec      = (state_q == plc_pkg::S_EXEC);
  assign pos_ext   = plc_pkg::CMP_W'(pos_q);
  assign cnt_ext   = plc_pkg::CMP_W'(count_q);
  assign in_range  = (pos_q != '0) && (pos_ext <= cnt_ext);
  assign ins_range = (pos_q != '0) && (pos_ext <= cnt_ext + 1'b1)
                     && (cnt_ext < plc_pkg::CMP_W'(plc_pkg::CAPACITY));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      plc_pkg::S_IDLE: if (start_i) state_d = plc_pkg::S_EXEC;
      plc_pkg::S_EXEC: state_d = plc_pkg::S_IDLE;
      default:         state_d = plc_pkg::S_IDLE;
    endcase
  end

  // outputs of the execute step
  always_comb begin
    cmd     = plc_pkg::CMD_NOP;
    ok_d    = 1'b0;
    vout_d  = '0;
    count_d = count_q;
    if (exec) begin
      unique case (func_q)
        plc_pkg::FUNC_READ: begin
          ok_d   = in_range;
          vout_d = in_range ? rd_value_i : '0;
        end
        plc_pkg::FUNC_INSERT: begin
          ok_d = ins_range;
          if (ins_range) begin
            cmd     = plc_pkg::CMD_INS;
            count_d = count_q + 1'b1;
          end
        end
        plc_pkg::FUNC_DELETE: begin
          ok_d   = in_range;
          vout_d = in_range ? rd_value_i : '0;
          if (in_range) begin
            cmd     = plc_pkg::CMD_DEL;
            count_d = count_q - 1'b1;
          end
        end
        plc_pkg::FUNC_CLEAR: begin
          ok_d    = 1'b1;
          count_d = '0;
        end
        default: ok_d = 1'b0;
      endcase
    end
  end

  assign ctl_o.cmd = cmd;
  assign ctl_o.p0  = plc_pkg::IDX_W'(pos_q - 1'b1);
  assign ctl_o.val = val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plc_pkg::S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!exec && start_i) begin
      func_q <= plc_pkg::func_e'(func_i);
      pos_q  <= position_i;
      val_q  <= value_in_i;
    end
    if (exec) begin
      ok_q   <= ok_d;
      vout_q <= vout_d;
    end
  end

  assign busy_o      = exec;
  assign done_o      = done_q;
  assign ok_o        = ok_q;
  assign value_out_o = vout_q;
  assign count_out_o = 6'(count_q);

`ifndef SYNTH
  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> done_o) else $error("execute step without result strobe");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("busy while result is shown");
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= plc_pkg::CNT_W'(plc_pkg::CAPACITY)) else $error("count above capacity");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !ok_o |-> value_out_o == '0) else $error("failed item carries a value");
  a_fail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && !ok_d |=> $stable(count_q)) else $error("failed item changed count");
`endif

endmodule
`default_nettype wire

@@ sv/positional_list_insert_delete.sv @@
// top level: positional list built as a chain of entry cells
//
// fixed-capacity ordered list of 32-bit entries addressed by 1-based position
// command channel: an item (func_i, position_i, value_in_i) is taken at a
// rising edge where start_i is high and busy_o is low
// func_i: read, insert, delete or clear; out-of-range positions, insert into
// a full list and read or delete on an empty list fail with ok_o low
// result channel: ok_o, value_out_o and count_out_o are valid for exactly one
// cycle while done_o is high; the receiver cannot stall, so nothing is held
// timing: the cycle after acceptance is the execute step (busy_o high), in
// which every cell at or past the position shifts toward or away from its
// neighbor at once and the selected entry is gathered through an or tree;
// done_o rises in the following cycle; no item is taken while busy_o is high;
// a new item may be taken in the cycle its predecessor's result is shown
// reset: asynchronous, active low; count goes to zero, entries stay undefined
// until inserted
`default_nettype none
module positional_list_insert_delete (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [5:0]  position_i,
  input  wire logic [31:0] value_in_i,
  output logic             done_o,
  output logic             ok_o,
  output logic      [31:0] value_out_o,
  output logic      [5:0]  count_out_o
);

  plc_pkg::cell_ctl_t         ctl;
  logic [plc_pkg::DATA_W-1:0] entry [plc_pkg::CAPACITY];
  logic [plc_pkg::DATA_W-1:0] hit   [plc_pkg::CAPACITY];
  logic [plc_pkg::DATA_W-1:0] rd_value;

  plc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .func_i      (func_i),
    .position_i  (position_i),
    .value_in_i  (value_in_i),
    .rd_value_i  (rd_value),
    .ctl_o       (ctl),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .ok_o        (ok_o),
    .value_out_o (value_out_o),
    .count_out_o (count_out_o)
  );

  for (genvar k = 0; k < plc_pkg::CAPACITY; k++) begin : g_cell
    logic [plc_pkg::DATA_W-1:0] left, right;
    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = entry[k-1];
    end
    if (k == plc_pkg::CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = entry[k+1];
    end
    plc_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .idx_i   (plc_pkg::IDX_W'(k)),
      .left_i  (left),
      .right_i (right),
      .entry_o (entry[k]),
      .hit_o   (hit[k])
    );
  end

  always_comb begin
    rd_value = '0;
    for (int k = 0; k < plc_pkg::CAPACITY; k++) begin
      rd_value = rd_value | hit[k];
    end
  end

endmodule
`default_nettype wire

@@ test/tb.sv @@
// testbench: positional list insert/delete checked against a built-in list predictor
module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_OPS  = 1830;
  localparam int MAX_PRINTS  = 100;

  typedef struct {
    plc_pkg::func_e             func;
    logic [plc_pkg::POS_W-1:0]  pos;
    logic [plc_pkg::DATA_W-1:0] val;
  } list_op_t;

  typedef struct {
    logic                       ok;
    logic [plc_pkg::DATA_W-1:0] value;
    logic [5:0]                 count;
  } list_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [1:0]        func_i;
  logic [5:0]        position_i;
  logic [31:0]       value_in_i;
  logic              done_o;
  logic              ok_o;
  logic [31:0]       value_out_o;
  logic [5:0]        count_out_o;

  list_op_t                   ops_to_send[$];
  list_result_t               expected_results[$];
  list_op_t                   op_on_port;
  logic [plc_pkg::DATA_W-1:0] list_mem [plc_pkg::CAPACITY];
  int                         list_len;
  int                         gen_len;
  int                         items_sent;
  int                         mismatches;
  int                         cycle_count;

  positional_list_insert_delete DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .func_i     (func_i),
    .position_i (position_i),
    .value_in_i (value_in_i),
    .done_o     (done_o),
    .ok_o       (ok_o),
    .value_out_o(value_out_o),
    .count_out_o(count_out_o)
  );

  function automatic list_result_t apply_list_op(list_op_t op);
    list_result_t r;
    int p;
    int k;
    r.ok    = 1'b0;
    r.value = '0;
    p       = op.pos;
    case (op.func)
      plc_pkg::FUNC_READ: begin
        if (p >= 1 && p <= list_len) begin
          r.ok    = 1'b1;
          r.value = list_mem[p-1];
        end
      end
      plc_pkg::FUNC_INSERT: begin
        if (list_len < plc_pkg::CAPACITY && p >= 1 && p <= list_len + 1) begin
          for (k = list_len; k > p - 1; k--) list_mem[k] = list_mem[k-1];
          list_mem[p-1] = op.val;
          list_len++;
          r.ok = 1'b1;
        end
      end
      plc_pkg::FUNC_DELETE: begin
        if (p >= 1 && p <= list_len) begin
          r.value = list_mem[p-1];
          for (k = p - 1; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      default: begin
        list_len = 0;
        r.ok     = 1'b1;
      end
    endcase
    r.count = list_len[5:0];
    return r;
  endfunction

  // queues an item and tracks the list length it leaves behind
  function automatic void queue_op(plc_pkg::func_e f, int p, logic [plc_pkg::DATA_W-1:0] v);
    list_op_t op;
    op.func = f;
    op.pos  = p[plc_pkg::POS_W-1:0];
    op.val  = v;
    ops_to_send.push_back(op);
    case (f)
      plc_pkg::FUNC_INSERT:
        if (gen_len < plc_pkg::CAPACITY && p >= 1 && p <= gen_len + 1) gen_len++;
      plc_pkg::FUNC_DELETE: if (p >= 1 && p <= gen_len) gen_len--;
      plc_pkg::FUNC_CLEAR:  gen_len = 0;
      default: ;
    endcase
  endfunction

  function automatic int pick_pos(int hi, bit valid);
    if (valid && hi >= 1) return $urandom_range(hi, 1);
    if ($urandom_range(1) == 0) return 0;
    return $urandom_range(63, hi + 1);
  endfunction

  function automatic logic [plc_pkg::DATA_W-1:0] pick_value();
    logic [plc_pkg::DATA_W-1:0] edges [5];
    edges = '{32'h0, 32'h1, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
    if ($urandom_range(99) < 15) return edges[$urandom_range(4)];
    return $urandom;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch %0s: got %h expected %h (item %0d)", what, got, want, items_sent);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        expected_results.push_back(apply_list_op(op_on_port));
        items_sent++;
      end
      if (!start_i || !busy_o) begin
        if (ops_to_send.size() != 0 &&
            !((items_sent < 600 || items_sent >= 1000) && $urandom_range(99) < 18)) begin
          op_on_port = ops_to_send.pop_front();
          start_i    <= 1'b1;
          func_i     <= op_on_port.func;
          position_i <= op_on_port.pos;
          value_in_i <= op_on_port.val;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", {26'd0, count_out_o}, 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (ok_o !== want.ok) report_mismatch("ok", {31'd0, ok_o}, {31'd0, want.ok});
        if (value_out_o !== want.value) report_mismatch("value", value_out_o, want.value);
        if (count_out_o !== want.count)
          report_mismatch("count", {26'd0, count_out_o}, {26'd0, want.count});
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int mode;
    int burst;
    int i;
    int r;
    plc_pkg::func_e f;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    func_i      = plc_pkg::FUNC_READ;
    position_i  = '0;
    value_in_i  = '0;
    list_len    = 0;
    gen_len     = 0;
    items_sent  = 0;
    mismatches  = 0;
    cycle_count = 0;

    // empty list, bad positions, boundary inserts and deletes, clear
    queue_op(plc_pkg::FUNC_READ,   1,  32'h0);
    queue_op(plc_pkg::FUNC_DELETE, 1,  32'h0);
    queue_op(plc_pkg::FUNC_INSERT, 0,  32'h1234_5678);
    queue_op(plc_pkg::FUNC_INSERT, 2,  32'h1234_5678);
    queue_op(plc_pkg::FUNC_INSERT, 1,  32'h8000_0000);
    queue_op(plc_pkg::FUNC_INSERT, 2,  32'h7fff_ffff);
    queue_op(plc_pkg::FUNC_INSERT, 1,  32'hffff_ffff);
    queue_op(plc_pkg::FUNC_INSERT, 4,  32'h0);
    queue_op(plc_pkg::FUNC_INSERT, 6,  32'h5555_aaaa);
    queue_op(plc_pkg::FUNC_INSERT, 63, 32'haaaa_5555);
    queue_op(plc_pkg::FUNC_READ,   0,  32'hffff_ffff);
    queue_op(plc_pkg::FUNC_READ,   4,  32'h0);
    queue_op(plc_pkg::FUNC_READ,   1,  32'h0);
    queue_op(plc_pkg::FUNC_READ,   5,  32'h0);
    queue_op(plc_pkg::FUNC_READ,   63, 32'h0);
    queue_op(plc_pkg::FUNC_DELETE, 0,  32'h0);
    queue_op(plc_pkg::FUNC_DELETE, 5,  32'h0);
    queue_op(plc_pkg::FUNC_DELETE, 2,  32'h0);
    queue_op(plc_pkg::FUNC_DELETE, 3,  32'h0);
    queue_op(plc_pkg::FUNC_DELETE, 1,  32'h0);
    queue_op(plc_pkg::FUNC_CLEAR,  0,  32'hffff_ffff);
    queue_op(plc_pkg::FUNC_CLEAR,  63, 32'h0);
    queue_op(plc_pkg::FUNC_READ,   1,  32'h0);

    // bursts: fill to full, drain, mixed traffic, raw noise
    i = 0;
    while (i < RANDOM_OPS) begin
      mode  = $urandom_range(99);
      burst = $urandom_range(40, 5);
      repeat (burst) begin
        if (mode < 30) begin
          queue_op(plc_pkg::FUNC_INSERT,
                   pick_pos(gen_len + 1, $urandom_range(99) < 90), pick_value());
        end else if (mode < 55) begin
          queue_op(plc_pkg::FUNC_DELETE,
                   pick_pos(gen_len, $urandom_range(99) < 90), pick_value());
        end else if (mode < 90) begin
          r = $urandom_range(99);
          if (r < 3) queue_op(plc_pkg::FUNC_CLEAR, $urandom_range(63), pick_value());
          else if (r < 38)
            queue_op(plc_pkg::FUNC_READ,
                     pick_pos(gen_len, $urandom_range(99) < 85), pick_value());
          else if (r < 69)
            queue_op(plc_pkg::FUNC_INSERT,
                     pick_pos(gen_len + 1, $urandom_range(99) < 85), pick_value());
          else
            queue_op(plc_pkg::FUNC_DELETE,
                     pick_pos(gen_len, $urandom_range(99) < 85), pick_value());
        end else begin
          f = plc_pkg::func_e'($urandom_range(3));
          queue_op(f, $urandom_range(63), $urandom);
        end
        i++;
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (ops_to_send.size() != 0 || start_i || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
